@@ hdl/btsf_pkg.sv @@
`default_nettype none
package btsf_pkg;

    localparam int SMOOTH_DEPTH_DEF = 50;
    localparam int FORECAST_LEN_DEF = 16;
    localparam int STEP_MS_DEF      = 10;

    localparam int POS_W  = 16;
    localparam int DT_W   = 20;
    localparam int URG_W  = 16;
    localparam int CFG_W  = 15;
    localparam int IDX_W  = 6;
    localparam int CERT_W = 16;
    localparam int BASE_W = 2 * (URG_W + 1);
    // signed product / dividend width, covers diff * 1e6 and vel * dt
    localparam int PROD_W = 38;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam int USEC_PER_SEC = 1000000;
    localparam int MSEC_PER_SEC = 1000;
    localparam int CERT_SHIFT   = 16;
    localparam int CERT_CUTOFF  = 63;

    // reciprocal scaling: floor(n / c) = ((n >> PRE) * RECIP) >> SHIFT over the operand range
    localparam int RECIP_W  = 30;
    // divide by 1e6 = 64 * 15625, dividend below 2^35
    localparam int US_PRE   = 6;
    localparam int US_SHIFT = 43;
    localparam logic [RECIP_W-1:0] US_RECIP = RECIP_W'(562949954);
    // divide by 1000 = 8 * 125, dividend below 2^31
    localparam int MS_PRE   = 3;
    localparam int MS_SHIFT = 35;
    localparam logic [RECIP_W-1:0] MS_RECIP = RECIP_W'(274877907);

    localparam logic [0:0] REG_HALF_LEN = 1'b0;
    localparam logic [0:0] REG_HALF_WID = 1'b1;

    localparam logic [CFG_W-1:0] HALF_LEN_RST = CFG_W'(4500);
    localparam logic [CFG_W-1:0] HALF_WID_RST = CFG_W'(3000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIVIDE,
        ST_SCALE,
        ST_APPLY
    } state_t;

    typedef enum logic [2:0] {
        JOB_POS_X,
        JOB_POS_Y,
        JOB_VEL_X,
        JOB_VEL_Y,
        JOB_FC_X,
        JOB_FC_Y
    } job_t;

    function automatic logic signed [POS_W-1:0] sat16(input logic signed [PROD_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v > (PROD_W+1)'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -(PROD_W+1)'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = POS_W'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/ball_track_smooth_and_forecast.sv @@
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata {urgency, elapsed_us, ball_y, ball_x}, s_tuser ball_found
// m_        out  m_tvalid/m_tready  m_tdata {certainty, vel_y, vel_x, pred_y, pred_x, step_index},
//                                   m_tlast last_step
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata
//
// The two velocity terms run the bit-serial divider by elapsed_us, one quotient bit per
// cycle; the averages, the lost-ball step and each forecast term take the load,
// reciprocal multiply and apply steps. The ring sits in a one-port synchronous memory.
// Reset (aresetn low, synchronous) clears sums, ring valid bits, history and handshakes.
// The final result may wait on m_tready while the next request is accepted; earlier
// results of a run stall the sequencer until taken.
module ball_track_smooth_and_forecast
    import btsf_pkg::*;
#(
    parameter int SMOOTH_DEPTH = SMOOTH_DEPTH_DEF,
    parameter int FORECAST_LEN = FORECAST_LEN_DEF,
    parameter int STEP_MS      = STEP_MS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [71:0]       s_tdata,   // ball_x, ball_y, elapsed_us, urgency, zero pad
    input  wire logic              s_tuser,   // ball_found
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [87:0]            m_tdata,   // step_index, pred_x, pred_y, vel_x, vel_y,
                                              // certainty, zero pad
    output logic                   m_tlast,
    input  wire logic              cfg_wr_en,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    localparam int PTR_W = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
    localparam int SUM_W = POS_W + $clog2(SMOOTH_DEPTH + 1);
    localparam int OFF_W = $clog2(FORECAST_LEN * STEP_MS + 1);
    // reciprocal of the ring depth, exact for every reachable sum magnitude
    localparam int AVG_SHIFT = POS_W - 1 + 2 * $clog2(SMOOTH_DEPTH);
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(SMOOTH_DEPTH) - 64'd1) / 64'(SMOOTH_DEPTH));

    state_t state_reg, state_next;
    job_t   job_reg;

    logic                      found_reg;
    logic signed [POS_W-1:0]   mx_reg, my_reg;
    logic [DT_W-1:0]           dt_reg;
    logic [URG_W-1:0]          urg_reg;
    logic [BASE_W-1:0]         base_reg;

    logic [2*POS_W-1:0]        ring_mem [SMOOTH_DEPTH];
    logic [2*POS_W-1:0]        rd_reg;
    logic [SMOOTH_DEPTH-1:0]   valid_reg;
    logic [PTR_W-1:0]          ptr_reg;
    logic signed [SUM_W-1:0]   sum_x_reg, sum_y_reg;

    logic signed [POS_W-1:0]   prev_px_reg, prev_py_reg, prev_vx_reg, prev_vy_reg;
    logic                      prev_valid_reg;
    logic signed [POS_W-1:0]   px_reg, py_reg, vx_reg, vy_reg, fx_reg;
    logic [IDX_W-1:0]          step_reg;
    logic [OFF_W-1:0]          off_reg;

    logic                      neg_reg;
    logic [PROD_W-1:0]         quo_reg;
    logic [DT_W-1:0]           rem_reg, divisor_reg;
    logic [CNT_W-1:0]          cnt_reg;

    logic [CFG_W-1:0]          half_len_reg, half_wid_reg;
    logic                      out_valid_reg;
    logic [87:0]               out_data_reg;
    logic                      out_last_reg;

    logic                      accept;
    logic                      mem_we;
    logic [2*POS_W-1:0]        old_entry;
    logic signed [17:0]        mul_a;
    logic [DT_W-1:0]           mul_b;
    logic signed [38:0]        prod_full;
    logic signed [PROD_W-1:0]  num;
    logic [DT_W-1:0]           divisor;
    logic [DT_W:0]             shifted;
    logic signed [PROD_W:0]    qs;
    logic signed [POS_W-1:0]   fy;
    logic [POS_W:0]            abs_fx, abs_fy;
    logic [6:0]                shamt;
    logic [BASE_W-1:0]         cert_full;
    logic [CERT_W-1:0]         cert;
    logic                      in_field;
    logic                      out_load;
    logic                      run_last;
    logic [RECIP_W-1:0]        sc_a, sc_b;
    logic [2*RECIP_W-1:0]      sc_prod;
    logic [PROD_W-1:0]         sc_quo;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign old_entry = valid_reg[ptr_reg] ? rd_reg : '0;
    assign mem_we    = (state_reg == ST_UPDATE) && found_reg;
    assign run_last  = (step_reg == IDX_W'(FORECAST_LEN - 1));
    assign out_load  = (state_reg == ST_APPLY) && (job_reg == JOB_FC_Y) &&
                       (!out_valid_reg || m_tready);

    // ring memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[ptr_reg] <= {my_reg, mx_reg};
        end
        rd_reg <= ring_mem[ptr_reg];
    end

    // dividend and divisor for the current job
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        divisor = DT_W'(1);
        case (job_reg)
            JOB_POS_X, JOB_POS_Y: begin
                mul_a   = 18'((job_reg == JOB_POS_X) ? prev_vx_reg : prev_vy_reg);
                mul_b   = dt_reg;
            end
            JOB_VEL_X, JOB_VEL_Y: begin
                mul_a   = (job_reg == JOB_VEL_X) ? (18'(px_reg) - 18'(prev_px_reg))
                                                 : (18'(py_reg) - 18'(prev_py_reg));
                mul_b   = DT_W'(USEC_PER_SEC);
                divisor = (dt_reg == '0) ? DT_W'(1) : dt_reg;
            end
            JOB_FC_X, JOB_FC_Y: begin
                mul_a   = 18'((job_reg == JOB_FC_X) ? vx_reg : vy_reg);
                mul_b   = DT_W'(off_reg);
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                divisor = DT_W'(1);
            end
        endcase
        prod_full = mul_a * signed'({1'b0, mul_b});
        if (found_reg && job_reg == JOB_POS_X) begin
            num = PROD_W'(sum_x_reg);
        end else if (found_reg && job_reg == JOB_POS_Y) begin
            num = PROD_W'(sum_y_reg);
        end else begin
            num = PROD_W'(prod_full);
        end
    end

    // constant divisors: prescale the magnitude (not for the ring average), multiply by the reciprocal, shift
    always_comb begin
        sc_a = '0;
        sc_b = '0;
        case (job_reg)
            JOB_POS_X, JOB_POS_Y: begin
                if (found_reg) begin
                    sc_a = RECIP_W'(quo_reg);
                    sc_b = AVG_RECIP;
                end else begin
                    sc_a = RECIP_W'(quo_reg >> US_PRE);
                    sc_b = US_RECIP;
                end
            end
            JOB_FC_X, JOB_FC_Y: begin
                sc_a = RECIP_W'(quo_reg >> MS_PRE);
                sc_b = MS_RECIP;
            end
            default: ;
        endcase
        sc_prod = sc_a * sc_b;
        if (job_reg == JOB_FC_X || job_reg == JOB_FC_Y) begin
            sc_quo = PROD_W'(sc_prod >> MS_SHIFT);
        end else if (found_reg) begin
            sc_quo = PROD_W'(sc_prod >> AVG_SHIFT);
        end else begin
            sc_quo = PROD_W'(sc_prod >> US_SHIFT);
        end
    end

    // divider step, signed quotient, forecast result
    always_comb begin
        shifted = {rem_reg, quo_reg[PROD_W-1]};
        qs      = signed'({1'b0, quo_reg});
        if (neg_reg) begin
            qs = -qs;
        end
        fy        = sat16((PROD_W+1)'(py_reg) + qs);
        abs_fx    = fx_reg[POS_W-1] ? (POS_W+1)'(-(POS_W+1)'(fx_reg)) : (POS_W+1)'(fx_reg);
        abs_fy    = fy[POS_W-1] ? (POS_W+1)'(-(POS_W+1)'(fy)) : (POS_W+1)'(fy);
        in_field  = (abs_fx <= (POS_W+1)'(half_len_reg) + (POS_W+1)'(1)) &&
                    (abs_fy <= (POS_W+1)'(half_wid_reg) + (POS_W+1)'(1));
        shamt     = 7'(CERT_SHIFT) + 7'(step_reg);
        cert_full = base_reg >> shamt;
        if (!in_field || shamt >= 7'(CERT_CUTOFF)) begin
            cert = '0;
        end else if (cert_full > BASE_W'(16'hFFFF)) begin
            cert = 16'hFFFF;
        end else begin
            cert = CERT_W'(cert_full);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_LOAD;
            ST_LOAD:   state_next = (job_reg == JOB_VEL_X || job_reg == JOB_VEL_Y) ?
                                    ST_DIVIDE : ST_SCALE;
            ST_DIVIDE: if (cnt_reg == CNT_W'(PROD_W - 1)) state_next = ST_APPLY;
            ST_SCALE:  state_next = ST_APPLY;
            ST_APPLY: begin
                if (job_reg != JOB_FC_Y) begin
                    state_next = ST_LOAD;
                end else if (out_load) begin
                    state_next = run_last ? ST_IDLE : ST_LOAD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            ptr_reg        <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            prev_px_reg    <= '0;
            prev_py_reg    <= '0;
            prev_vx_reg    <= '0;
            prev_vy_reg    <= '0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            half_len_reg   <= HALF_LEN_RST;
            half_wid_reg   <= HALF_WID_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HALF_LEN: half_len_reg <= cfg_wdata;
                    REG_HALF_WID: half_wid_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (mem_we) begin
                valid_reg[ptr_reg] <= 1'b1;
                sum_x_reg <= sum_x_reg + SUM_W'(mx_reg) - SUM_W'(signed'(old_entry[15:0]));
                sum_y_reg <= sum_y_reg + SUM_W'(my_reg) - SUM_W'(signed'(old_entry[31:16]));
                ptr_reg   <= (ptr_reg == PTR_W'(SMOOTH_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            // commit history when the run ends
            if (out_load && run_last) begin
                prev_px_reg    <= px_reg;
                prev_py_reg    <= py_reg;
                prev_vx_reg    <= vx_reg;
                prev_vy_reg    <= vy_reg;
                prev_valid_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    found_reg <= s_tuser;
                    mx_reg    <= s_tdata[15:0];
                    my_reg    <= s_tdata[31:16];
                    dt_reg    <= s_tdata[51:32];
                    urg_reg   <= s_tdata[67:52];
                end
            end
            ST_UPDATE: begin
                base_reg <= (17'h10000 - 17'(urg_reg)) * (17'h10000 - 17'(urg_reg));
                job_reg  <= JOB_POS_X;
                step_reg <= '0;
                off_reg  <= '0;
            end
            ST_LOAD: begin
                neg_reg     <= num[PROD_W-1];
                quo_reg     <= num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
                rem_reg     <= '0;
                divisor_reg <= divisor;
                cnt_reg     <= '0;
            end
            ST_DIVIDE: begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (shifted >= {1'b0, divisor_reg}) begin
                    rem_reg <= DT_W'(shifted - {1'b0, divisor_reg});
                    quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= DT_W'(shifted);
                    quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
                end
            end
            ST_SCALE: begin
                quo_reg <= sc_quo;
            end
            ST_APPLY: begin
                case (job_reg)
                    JOB_POS_X: begin
                        px_reg  <= found_reg ? sat16(qs) : sat16((PROD_W+1)'(prev_px_reg) + qs);
                        job_reg <= JOB_POS_Y;
                    end
                    JOB_POS_Y: begin
                        py_reg  <= found_reg ? sat16(qs) : sat16((PROD_W+1)'(prev_py_reg) + qs);
                        job_reg <= JOB_VEL_X;
                    end
                    JOB_VEL_X: begin
                        vx_reg  <= prev_valid_reg ? sat16(qs) : '0;
                        job_reg <= JOB_VEL_Y;
                    end
                    JOB_VEL_Y: begin
                        vy_reg  <= prev_valid_reg ? sat16(qs) : '0;
                        job_reg <= JOB_FC_X;
                    end
                    JOB_FC_X: begin
                        fx_reg  <= sat16((PROD_W+1)'(px_reg) + qs);
                        job_reg <= JOB_FC_Y;
                    end
                    JOB_FC_Y: begin
                        if (out_load) begin
                            out_data_reg <= {2'b00, cert, vy_reg, vx_reg, fy, fx_reg, step_reg};
                            out_last_reg <= run_last;
                            step_reg     <= step_reg + IDX_W'(1);
                            off_reg      <= off_reg + OFF_W'(STEP_MS);
                            job_reg      <= JOB_FC_X;
                        end
                    end
                    default: job_reg <= JOB_POS_X;
                endcase
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/btsf_checker.sv @@
`default_nettype none
module btsf_checker
    import btsf_pkg::*;
#(
    parameter int FORECAST_LEN = FORECAST_LEN_DEF
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic        m_tlast
);

    // a request starts a run, so the input closes right after
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a request");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[5:0] == IDX_W'(FORECAST_LEN - 1))
        else $error("last step has wrong index");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ball_track_smooth_and_forecast btsf_checker #(.FORECAST_LEN(FORECAST_LEN)) u_btsf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

@@ sim/ball_track_smooth_and_forecast_tb.sv @@
`timescale 1ns / 1ps

module ball_track_smooth_and_forecast_tb;
    import btsf_pkg::*;

    localparam int DEPTH      = SMOOTH_DEPTH_DEF;
    localparam int FC_LEN     = FORECAST_LEN_DEF;
    localparam int STEP       = STEP_MS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 40;

    typedef struct {
        logic [IDX_W-1:0]         step;
        logic signed [POS_W-1:0]  fx;
        logic signed [POS_W-1:0]  fy;
        logic signed [POS_W-1:0]  vx;
        logic signed [POS_W-1:0]  vy;
        logic [CERT_W-1:0]        cert;
        logic                     last;
    } forecast_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [71:0]       s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [87:0]       m_tdata;
    logic              m_tlast;
    logic              cfg_wr_en = 1'b0;
    logic [0:0]        cfg_index = REG_HALF_LEN;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    ball_track_smooth_and_forecast u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // tracker copy
    logic signed [POS_W-1:0] ring_x [DEPTH];
    logic signed [POS_W-1:0] ring_y [DEPTH];
    int  ring_ptr;
    int  acc_x, acc_y;
    int  last_px, last_py, last_vx, last_vy;
    bit  last_valid;
    int  half_len, half_wid;

    forecast_t forecast_q[$];
    int  errors = 0;
    bit  idle_en = 1'b1;
    int  rx_hold = 0;
    int  rx_gap = 0;
    int  quiet_cycles = 0;

    function automatic int clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic track_cycle(input bit found, input logic signed [POS_W-1:0] x,
                               input logic signed [POS_W-1:0] y,
                               input logic [DT_W-1:0] dt_bits, input logic [URG_W-1:0] urg);
        int px, py, vx, vy, i;
        longint dt, d, base, fx, fy, cert;
        bit ins;
        forecast_t f;
        dt = longint'(dt_bits);
        if (found) begin
            acc_x = acc_x + int'(x) - int'(ring_x[ring_ptr]);
            acc_y = acc_y + int'(y) - int'(ring_y[ring_ptr]);
            ring_x[ring_ptr] = x;
            ring_y[ring_ptr] = y;
            ring_ptr = (ring_ptr + 1) % DEPTH;
            px = clamp16(acc_x / DEPTH);
            py = clamp16(acc_y / DEPTH);
        end else begin
            px = clamp16(longint'(last_px) + (longint'(last_vx) * dt) / USEC_PER_SEC);
            py = clamp16(longint'(last_py) + (longint'(last_vy) * dt) / USEC_PER_SEC);
        end
        if (last_valid) begin
            d = (dt == 0) ? 1 : dt;
            vx = clamp16((longint'(px - last_px) * USEC_PER_SEC) / d);
            vy = clamp16((longint'(py - last_py) * USEC_PER_SEC) / d);
        end else begin
            vx = 0;
            vy = 0;
        end
        base = (65536 - longint'(urg)) * (65536 - longint'(urg));
        for (i = 0; i < FC_LEN; i++) begin
            fx = clamp16(longint'(px) + (longint'(vx) * (i * STEP)) / MSEC_PER_SEC);
            fy = clamp16(longint'(py) + (longint'(vy) * (i * STEP)) / MSEC_PER_SEC);
            ins = mag(fx) <= half_len + 1 && mag(fy) <= half_wid + 1;
            cert = 0;
            if (ins && CERT_SHIFT + i < CERT_CUTOFF) begin
                cert = base >> (CERT_SHIFT + i);
                if (cert > 65535) cert = 65535;
            end
            f.step = IDX_W'(i);
            f.fx   = POS_W'(fx);
            f.fy   = POS_W'(fy);
            f.vx   = POS_W'(vx);
            f.vy   = POS_W'(vy);
            f.cert = CERT_W'(cert);
            f.last = (i == FC_LEN - 1);
            forecast_q.push_back(f);
        end
        last_px = px;
        last_py = py;
        last_vx = vx;
        last_vy = vy;
        last_valid = 1'b1;
    endtask

    // one request; tvalid stays high after acceptance so the next call can follow directly
    task automatic send_cycle(input bit found, input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y,
                              input logic [DT_W-1:0] dt, input logic [URG_W-1:0] urg);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= found;
        s_tdata  <= {4'b0, urg, dt, y, x};
        do @(posedge aclk); while (!s_tready);
        track_cycle(found, x, y, dt, urg);
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (forecast_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_HALF_LEN) half_len = value;
        else half_wid = value;
    endtask

    task automatic send_random_cycle();
        bit found;
        logic signed [POS_W-1:0] x, y;
        logic [DT_W-1:0] dt;
        logic [URG_W-1:0] urg;
        found = $urandom_range(0, 9) < 7;
        if ($urandom_range(0, 4) == 0) begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
        end else begin
            // ball moving around a point near the last estimate
            x = POS_W'(clamp16(last_px + int'($urandom_range(0, 400)) - 200));
            y = POS_W'(clamp16(last_py + int'($urandom_range(0, 400)) - 200));
        end
        dt  = ($urandom_range(0, 3) == 0) ? DT_W'($urandom_range(1, USEC_PER_SEC))
                                          : DT_W'($urandom_range(1000, 40000));
        urg = URG_W'($urandom);
        send_cycle(found, x, y, dt, urg);
    endtask

    // receiver back-pressure
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_gap   <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        forecast_t e;
        forecast_t a;
        if (m_tvalid && m_tready) begin
            a.step = m_tdata[5:0];
            a.fx   = m_tdata[21:6];
            a.fy   = m_tdata[37:22];
            a.vx   = m_tdata[53:38];
            a.vy   = m_tdata[69:54];
            a.cert = m_tdata[85:70];
            a.last = m_tlast;
            if (forecast_q.size() == 0) begin
                $display("%0t: unexpected result step %0d", $time, a.step);
                errors++;
            end else begin
                e = forecast_q.pop_front();
                if (a.step !== e.step) begin
                    $display("%0t: step_index exp %0d act %0d", $time, e.step, a.step);
                    errors++;
                end
                if (a.fx !== e.fx) begin
                    $display("%0t: pred_x exp %0d act %0d", $time, e.fx, a.fx);
                    errors++;
                end
                if (a.fy !== e.fy) begin
                    $display("%0t: pred_y exp %0d act %0d", $time, e.fy, a.fy);
                    errors++;
                end
                if (a.vx !== e.vx) begin
                    $display("%0t: vel_x exp %0d act %0d", $time, e.vx, a.vx);
                    errors++;
                end
                if (a.vy !== e.vy) begin
                    $display("%0t: vel_y exp %0d act %0d", $time, e.vy, a.vy);
                    errors++;
                end
                if (a.cert !== e.cert) begin
                    $display("%0t: certainty exp %0d act %0d", $time, e.cert, a.cert);
                    errors++;
                end
                if (a.last !== e.last) begin
                    $display("%0t: last_step exp %0d act %0d", $time, e.last, a.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        send_cycle(1'b0, 16'sd5, 16'sd7, 20'd1000, 16'd0);          // lost ball at start
        send_cycle(1'b1, 16'sh7FFF, 16'sh8000, 20'd1, 16'd65535);
        send_cycle(1'b1, 16'sh8000, 16'sh7FFF, 20'd1, 16'd0);
        send_cycle(1'b1, 16'sh7FFF, 16'sh7FFF, 20'd0, 16'd32768);   // zero elapsed time
        send_cycle(1'b0, 16'sd0, 16'sd0, 20'd1000000, 16'd1);
        send_cycle(1'b0, 16'sd0, 16'sd0, 20'hFFFFF, 16'hAAAA);
        send_cycle(1'b1, 16'sh5555, 16'shAAAA, 20'h55555, 16'h5555);
        send_cycle(1'b1, 16'sd100, -16'sd100, 20'd10000, 16'd1000);
        send_cycle(1'b0, 16'sh7FFF, 16'sh7FFF, 20'd20000, 16'd1);
    endtask

    task automatic test_field_limits();
        write_reg(REG_HALF_LEN, 0);
        write_reg(REG_HALF_WID, 0);
        send_cycle(1'b1, 16'sd0, 16'sd0, 20'd10000, 16'd0);
        send_cycle(1'b1, 16'sd60, -16'sd60, 20'd10000, 16'd100);
        write_reg(REG_HALF_LEN, 32767);
        write_reg(REG_HALF_WID, 32767);
        send_cycle(1'b1, 16'sh8000, 16'sh7FFF, 20'd1, 16'd0);
        send_cycle(1'b0, 16'sd0, 16'sd0, 20'd5000, 16'd200);
        write_reg(REG_HALF_LEN, 4500);
        write_reg(REG_HALF_WID, 3000);
    endtask

    task automatic test_back_pressure();
        wait_drained();
        rx_hold = 5000;
        repeat (6) send_random_cycle();
        wait_drained();
        send_random_cycle();
        wait_drained();
        send_random_cycle();
    endtask

    task automatic test_random_tracks();
        int n;
        for (n = 0; n < 100; n++) begin
            if (n % 25 == 24) begin
                write_reg(REG_HALF_LEN, $urandom_range(0, 32767));
                write_reg(REG_HALF_WID, $urandom_range(0, 32767));
            end
            send_random_cycle();
        end
    endtask

    task automatic test_no_idle_tail();
        wait_drained();
        idle_en = 1'b0;
        repeat (10) send_random_cycle();
    endtask

    initial begin
        int i;
        for (i = 0; i < DEPTH; i++) begin
            ring_x[i] = 0;
            ring_y[i] = 0;
        end
        ring_ptr = 0; acc_x = 0; acc_y = 0;
        last_px = 0; last_py = 0; last_vx = 0; last_vy = 0; last_valid = 1'b0;
        half_len = 4500; half_wid = 3000;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_field_limits();
        test_back_pressure();
        test_random_tracks();
        test_no_idle_tail();
        wait_drained();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
